@@ rtl/core/rid_pkg.sv @@
// Package for the resident ID validator core.
// Types, constants and helper functions shared by the pipeline stages.
// No dependencies.
`default_nettype none

package rid_pkg;

    localparam int NUM_OLD  = 15;
    localparam int NUM_NEW  = 18;
    localparam int NUM_WIDE = 17;
    localparam int NUM_CODE = 11;

    localparam int OLD_W  = 4 * NUM_OLD;
    localparam int NEW_W  = 4 * NUM_NEW;
    localparam int HALF_W = NEW_W / 2;

    typedef logic [3:0] t_nib;

    localparam t_nib WEIGHT_TAB [NUM_WIDE] = '{
        4'd7, 4'd9, 4'd10, 4'd5, 4'd8, 4'd4, 4'd2, 4'd1, 4'd6,
        4'd3, 4'd7, 4'd9, 4'd10, 4'd5, 4'd8, 4'd4, 4'd2
    };
    localparam t_nib CODE_TAB [NUM_CODE] = '{
        4'd1, 4'd0, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2
    };

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_YEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_DAY   = 2'd2;

    localparam logic [13:0] RST_REF_YEAR  = 14'd2017;
    localparam logic [3:0]  RST_REF_MONTH = 4'd5;
    localparam logic [4:0]  RST_REF_DAY   = 5'd10;

    localparam logic [13:0] YEAR_1900 = 14'd1900;
    localparam logic [13:0] YEAR_2000 = 14'd2000;
    localparam logic [6:0]  LONG_TERM = 7'd100;
    localparam t_nib        MAX_DIGIT = 4'd9;

    // y / 100 = (y * 5243) >> 19, exact for 14-bit y
    localparam logic [12:0] HUND_RECIP = 13'd5243;
    localparam logic [13:0] HUND       = 14'd100;
    // s / 11 = (s * 2979) >> 15, exact for 11-bit weighted sums
    localparam logic [11:0] ELEV_RECIP = 12'd2979;
    localparam logic [10:0] ELEV       = 11'd11;
    // v / 10 = (v * 205) >> 11, exact below 1029
    localparam logic [7:0]  TEN_RECIP  = 8'd205;

    typedef struct packed {
        logic [OLD_W-1:0]  old_digits;
        logic [NEW_W-1:0]  new_chars;
        logic [1:0]        extra_chars;
        logic [13:0]       birth_year;
        logic [3:0]        birth_month;
        logic [5:0]        birth_day;
        logic [13:0]       issue_year;
        logic [3:0]        issue_month;
        logic [5:0]        issue_day;
        logic [6:0]        valid_years;
    } t_rec;

    typedef struct packed {
        logic [13:0] ref_year;
        logic [3:0]  ref_month;
        logic [4:0]  ref_day;
    } t_ref;

    typedef struct packed {
        logic [OLD_W-1:0] old_digits;
        logic [NEW_W-1:0] new_chars;
        logic             ext_bad;
        logic             digits;
        logic [13:0]      birth_year;
        logic [7:0]       birth_q;
        logic [3:0]       birth_month;
        logic [5:0]       birth_day;
        logic [13:0]      issue_year;
        logic [7:0]       issue_q;
        logic [3:0]       issue_month;
        logic [5:0]       issue_day;
        logic [14:0]      exp_year;
        logic             long_term;
        logic [7:0]       cent;
        logic [10:0]      psum_a;
        logic [10:0]      psum_b;
    } t_s1;

    typedef struct packed {
        logic [OLD_W-1:0] old_digits;
        logic [NEW_W-1:0] new_chars;
        logic             ok;
        logic             digits;
        logic [6:0]       birth_rem;
        logic [7:0]       cent;
        logic [10:0]      sum;
        logic [6:0]       sum_q;
    } t_s2;

    function automatic logic is_leap(input logic [1:0] y_low, input logic [1:0] q_low,
                                     input logic rem_zero);
        is_leap = rem_zero ? (q_low == 2'd0) : (y_low == 2'd0);
    endfunction

    function automatic logic date_ok(input logic [3:0] m, input logic [5:0] d,
                                     input logic leap);
        logic [5:0] top;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11:                 top = 6'd30;
            4'd2:                                    top = leap ? 6'd29 : 6'd28;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: top = 6'd31;
            default:                                 top = 6'd0;
        endcase
        date_ok = (d != 6'd0) && (d <= top);
    endfunction

    // character i of the widened 17-digit number
    function automatic t_nib wide_char(input logic [OLD_W-1:0] old, input logic [7:0] cent,
                                       input int i);
        if (i < 6)
            wide_char = old[4*(NUM_OLD-1-i) +: 4];
        else if (i == 6)
            wide_char = cent[7:4];
        else if (i == 7)
            wide_char = cent[3:0];
        else
            wide_char = old[4*(NUM_OLD+1-i) +: 4];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rid_sum_stage.sv @@
// Stage 1: digit scan, century insertion, weighted half sums, year quotients.
// Depends on rid_pkg.
`default_nettype none

module rid_sum_stage import rid_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_rec i_rec,
    output t_s1       o_s1
);

    t_s1         r_s1;
    t_s1         n_s1;
    logic [26:0] by_prod;
    logic [26:0] iy_prod;
    logic [10:0] term;

    always_comb begin
        n_s1             = '0;
        n_s1.old_digits  = i_rec.old_digits;
        n_s1.new_chars   = i_rec.new_chars;
        n_s1.ext_bad     = |i_rec.extra_chars;
        n_s1.birth_year  = i_rec.birth_year;
        n_s1.birth_month = i_rec.birth_month;
        n_s1.birth_day   = i_rec.birth_day;
        n_s1.issue_year  = i_rec.issue_year;
        n_s1.issue_month = i_rec.issue_month;
        n_s1.issue_day   = i_rec.issue_day;
        n_s1.exp_year    = 15'(i_rec.issue_year) + 15'(i_rec.valid_years);
        n_s1.long_term   = (i_rec.valid_years == LONG_TERM);

        by_prod = 27'(i_rec.birth_year) * 27'(HUND_RECIP);
        iy_prod = 27'(i_rec.issue_year) * 27'(HUND_RECIP);
        n_s1.birth_q = by_prod[26:19];
        n_s1.issue_q = iy_prod[26:19];

        n_s1.digits = 1'b1;
        for (int i = 0; i < NUM_OLD; i++) begin
            if (i_rec.old_digits[4*(NUM_OLD-1-i) +: 4] > MAX_DIGIT)
                n_s1.digits = 1'b0;
        end

        if (i_rec.birth_year >= YEAR_2000)
            n_s1.cent = {4'd2, 4'd0};
        else if (i_rec.birth_year >= YEAR_1900)
            n_s1.cent = {4'd1, 4'd9};
        else
            n_s1.cent = i_rec.old_digits[4*(NUM_OLD-8) +: 8];

        for (int i = 0; i < NUM_WIDE; i++) begin
            term = 11'(wide_char(i_rec.old_digits, n_s1.cent, i)) * 11'(WEIGHT_TAB[i]);
            if (i < 9)
                n_s1.psum_a = n_s1.psum_a + term;
            else
                n_s1.psum_b = n_s1.psum_b + term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

@@ rtl/core/rid_check_stage.sv @@
// Stage 2: calendar checks, birth month/day match, expiry compare, mod-11 quotient.
// Depends on rid_pkg.
`default_nettype none

module rid_check_stage import rid_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_s1  i_s1,
    input  wire t_ref i_ref,
    output t_s2       o_s2
);

    t_s2         r_s2;
    t_s2         n_s2;
    logic [13:0] by_rem;
    logic [13:0] iy_rem;
    logic        b_leap;
    logic        i_leap;
    logic [13:0] bd_prod;
    logic [2:0]  bd_tens;
    logic [5:0]  bd_ones;
    logic        bm_tens;
    logic [3:0]  bm_ones;
    logic        bd_bm_ok;
    logic        exp_ok;
    logic [22:0] sum_prod;

    always_comb begin
        by_rem = i_s1.birth_year - 14'(i_s1.birth_q) * HUND;
        iy_rem = i_s1.issue_year - 14'(i_s1.issue_q) * HUND;
        b_leap = is_leap(i_s1.birth_year[1:0], i_s1.birth_q[1:0], by_rem == 14'd0);
        i_leap = is_leap(i_s1.issue_year[1:0], i_s1.issue_q[1:0], iy_rem == 14'd0);

        bd_prod = 14'(i_s1.birth_day) * 14'(TEN_RECIP);
        bd_tens = bd_prod[13:11];
        bd_ones = i_s1.birth_day - 6'(bd_tens) * 6'd10;
        bm_tens = (i_s1.birth_month >= 4'd10);
        bm_ones = bm_tens ? i_s1.birth_month - 4'd10 : i_s1.birth_month;

        bd_bm_ok = (i_s1.old_digits[4*(NUM_OLD-11) +: 4] == 4'(bd_tens))
                && (i_s1.old_digits[4*(NUM_OLD-12) +: 4] == bd_ones[3:0])
                && (i_s1.old_digits[4*(NUM_OLD-9) +: 4] == 4'(bm_tens))
                && (i_s1.old_digits[4*(NUM_OLD-10) +: 4] == bm_ones);

        if (i_s1.long_term)
            exp_ok = 1'b1;
        else if (i_s1.exp_year != 15'(i_ref.ref_year))
            exp_ok = (i_s1.exp_year > 15'(i_ref.ref_year));
        else if (i_s1.issue_month != i_ref.ref_month)
            exp_ok = (i_s1.issue_month > i_ref.ref_month);
        else
            exp_ok = (i_s1.issue_day >= 6'(i_ref.ref_day));

        n_s2.old_digits = i_s1.old_digits;
        n_s2.new_chars  = i_s1.new_chars;
        n_s2.digits     = i_s1.digits;
        n_s2.cent       = i_s1.cent;
        n_s2.birth_rem  = by_rem[6:0];
        n_s2.ok = !i_s1.ext_bad && i_s1.digits && bd_bm_ok && exp_ok
               && date_ok(i_s1.birth_month, i_s1.birth_day, b_leap)
               && date_ok(i_s1.issue_month, i_s1.issue_day, i_leap);

        n_s2.sum   = i_s1.psum_a + i_s1.psum_b;
        sum_prod   = 23'(n_s2.sum) * 23'(ELEV_RECIP);
        n_s2.sum_q = sum_prod[21:15];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

@@ rtl/core/rid_match_stage.sv @@
// Stage 3: check character, birth year digit match, full new-number compare.
// Depends on rid_pkg.
`default_nettype none

module rid_match_stage import rid_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire t_s2        i_s2,
    output logic            o_id_valid,
    output logic [3:0]      o_check_char
);

    logic        r_id_valid;
    logic [3:0]  r_check_char;
    logic        n_id_valid;
    logic [3:0]  n_check_char;
    logic [10:0] rem_w;
    logic [14:0] yr_prod;
    logic [3:0]  yr_tens;
    logic [6:0]  yr_ones;
    logic        match;

    always_comb begin
        rem_w = i_s2.sum - 11'(i_s2.sum_q) * ELEV;
        n_check_char = 4'd0;
        if (i_s2.digits) begin
            for (int k = 0; k < NUM_CODE; k++) begin
                if (rem_w[3:0] == 4'(k))
                    n_check_char = CODE_TAB[k];
            end
        end

        yr_prod = 15'(i_s2.birth_rem) * 15'(TEN_RECIP);
        yr_tens = yr_prod[14:11];
        yr_ones = i_s2.birth_rem - 7'(yr_tens) * 7'd10;

        match = (i_s2.old_digits[4*(NUM_OLD-7) +: 4] == yr_tens)
             && (i_s2.old_digits[4*(NUM_OLD-8) +: 4] == yr_ones[3:0])
             && (i_s2.new_chars[3:0] == n_check_char);
        for (int i = 0; i < NUM_WIDE; i++) begin
            if (i_s2.new_chars[4*(NUM_NEW-1-i) +: 4] != wide_char(i_s2.old_digits, i_s2.cent, i))
                match = 1'b0;
        end
        n_id_valid = i_s2.ok && match;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_id_valid   <= n_id_valid;
            r_check_char <= n_check_char;
        end
    end

    assign o_id_valid   = r_id_valid;
    assign o_check_char = r_check_char;

endmodule

`default_nettype wire

@@ rtl/core/resident_id_validator_core.sv @@
// Resident ID validator: one record per cycle while the output is not stalled, through three
// register stages (sum stage, check stage, match stage) that each record passes in that order.
// A stalled output backs up the pipeline, and empty stages keep taking records.
// Reference date registers are written by index.
// Depends on rid_pkg, rid_sum_stage, rid_check_stage, rid_match_stage.
`default_nettype none

module resident_id_validator_core import rid_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [OLD_W-1:0]     i_old_digits,
    input  wire logic [HALF_W-1:0]    i_new_head,
    input  wire logic [HALF_W-1:0]    i_new_tail,
    input  wire logic [1:0]           i_extra_chars,
    input  wire logic [13:0]          i_birth_year,
    input  wire logic [3:0]           i_birth_month,
    input  wire logic [5:0]           i_birth_day,
    input  wire logic [13:0]          i_issue_year,
    input  wire logic [3:0]           i_issue_month,
    input  wire logic [5:0]           i_issue_day,
    input  wire logic [6:0]           i_valid_years,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_id_valid,
    output logic [3:0]                o_check_char,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [13:0]          i_cfg_data
);

    t_ref       r_ref;
    logic [2:0] r_v;
    logic [2:0] adv;
    t_rec       rec;
    t_s1        s1;
    t_s2        s2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref.ref_year  <= RST_REF_YEAR;
            r_ref.ref_month <= RST_REF_MONTH;
            r_ref.ref_day   <= RST_REF_DAY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REF_YEAR:  r_ref.ref_year  <= i_cfg_data;
                CFG_REF_MONTH: r_ref.ref_month <= i_cfg_data[3:0];
                CFG_REF_DAY:   r_ref.ref_day   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // a stage advances when it is empty or the stage after it advances
    assign adv[2]  = !r_v[2] || !i_stall;
    assign adv[1]  = !r_v[1] || adv[2];
    assign adv[0]  = !r_v[0] || adv[1];
    assign o_stall = !adv[0];
    assign o_valid = r_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
        end
    end

    always_comb begin
        rec.old_digits  = i_old_digits;
        rec.new_chars   = {i_new_head, i_new_tail};
        rec.extra_chars = i_extra_chars;
        rec.birth_year  = i_birth_year;
        rec.birth_month = i_birth_month;
        rec.birth_day   = i_birth_day;
        rec.issue_year  = i_issue_year;
        rec.issue_month = i_issue_month;
        rec.issue_day   = i_issue_day;
        rec.valid_years = i_valid_years;
    end

    rid_sum_stage u_sum (
        .i_clk (i_clk),
        .i_en  (adv[0]),
        .i_rec (rec),
        .o_s1  (s1)
    );

    rid_check_stage u_check (
        .i_clk (i_clk),
        .i_en  (adv[1]),
        .i_s1  (s1),
        .i_ref (r_ref),
        .o_s2  (s2)
    );

    rid_match_stage u_match (
        .i_clk        (i_clk),
        .i_en         (adv[2]),
        .i_s2         (s2),
        .o_id_valid   (o_id_valid),
        .o_check_char (o_check_char)
    );

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v == 3'b111))
        else $error("input stalled with an empty stage");

    a_stage0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !adv[1]) |=> r_v[0])
        else $error("stage 1 transaction lost while blocked");

    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !adv[2]) |=> r_v[1])
        else $error("stage 2 transaction lost while blocked");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_check_char <= 4'd10))
        else $error("check character out of range");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Testbench for resident_id_validator_core: directed and random identity records checked
// against an in-bench predictor of the mod-11 check, date and expiry rules.
// Depends on rid_pkg and resident_id_validator_core.
`default_nettype none

module tb;
    import rid_pkg::*;

    typedef struct packed {
        logic [OLD_W-1:0]  old_digits;
        logic [HALF_W-1:0] new_head;
        logic [HALF_W-1:0] new_tail;
        logic [1:0]        extra_chars;
        logic [13:0]       birth_year;
        logic [3:0]        birth_month;
        logic [5:0]        birth_day;
        logic [13:0]       issue_year;
        logic [3:0]        issue_month;
        logic [5:0]        issue_day;
        logic [6:0]        valid_years;
    } id_rec_t;

    typedef struct packed {
        logic       id_valid;
        logic [3:0] check_char;
    } id_res_t;

    localparam int CHECK_WEIGHT [17] = '{7, 9, 10, 5, 8, 4, 2, 1, 6, 3, 7, 9, 10, 5, 8, 4, 2};
    localparam logic [3:0] CHECK_CODE [11] = '{1, 0, 10, 9, 8, 7, 6, 5, 4, 3, 2};
    localparam logic [3:0] CHAR_X = 4'd10;
    localparam logic [6:0] LONG_TERM_YEARS = 7'd100;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    id_rec_t              drv_rec = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_id_valid;
    logic [3:0]           o_check_char;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_REF_YEAR;
    logic [13:0]          i_cfg_data = '0;

    logic [13:0] ref_year_q = 14'd2017;
    logic [3:0]  ref_month_q = 4'd5;
    logic [4:0]  ref_day_q = 5'd10;

    id_rec_t pending_records [$];
    id_res_t predicted_results [$];
    int      n_issued = 0;
    int      n_sent = 0;
    int      n_results = 0;
    int      n_ids_ok = 0;
    int      n_x_checks = 0;
    int      n_errors = 0;
    int      send_gap_pct = 0;
    int      hold_pct = 0;

    resident_id_validator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_old_digits  (drv_rec.old_digits),
        .i_new_head    (drv_rec.new_head),
        .i_new_tail    (drv_rec.new_tail),
        .i_extra_chars (drv_rec.extra_chars),
        .i_birth_year  (drv_rec.birth_year),
        .i_birth_month (drv_rec.birth_month),
        .i_birth_day   (drv_rec.birth_day),
        .i_issue_year  (drv_rec.issue_year),
        .i_issue_month (drv_rec.issue_month),
        .i_issue_day   (drv_rec.issue_day),
        .i_valid_years (drv_rec.valid_years),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_id_valid    (o_id_valid),
        .o_check_char  (o_check_char),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned month_days(int unsigned y, int unsigned m);
        case (m)
            4, 6, 9, 11: return 30;
            2: return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default: return 0;
        endcase
    endfunction

    function automatic logic date_valid(int unsigned y, int unsigned m, int unsigned d);
        return d >= 1 && d <= month_days(y, m);
    endfunction

    function automatic logic [3:0] old_char(logic [OLD_W-1:0] old, int unsigned pos);
        return old[4*(14-pos) +: 4];
    endfunction

    function automatic logic [3:0] new_char(id_rec_t r, int unsigned pos);
        return (pos < 9) ? r.new_head[4*(8-pos) +: 4] : r.new_tail[4*(17-pos) +: 4];
    endfunction

    function automatic id_rec_t set_old_char(id_rec_t r, int unsigned pos, logic [3:0] nib);
        r.old_digits[4*(14-pos) +: 4] = nib;
        return r;
    endfunction

    function automatic id_rec_t set_new_char(id_rec_t r, int unsigned pos, logic [3:0] nib);
        if (pos < 9) begin
            r.new_head[4*(8-pos) +: 4] = nib;
        end else begin
            r.new_tail[4*(17-pos) +: 4] = nib;
        end
        return r;
    endfunction

    function automatic id_res_t predict_id(id_rec_t r);
        logic [3:0]  wide [18];
        logic        digits;
        logic        ok;
        int unsigned by, bm, bd, sum, ey, i;
        id_res_t     res;
        by = r.birth_year;
        bm = r.birth_month;
        bd = r.birth_day;
        digits = 1'b1;
        for (i = 0; i < 15; i++) begin
            if (old_char(r.old_digits, i) > 4'd9) digits = 1'b0;
        end
        ok = digits && (r.extra_chars == 2'b00) && date_valid(by, bm, bd)
             && date_valid(r.issue_year, r.issue_month, r.issue_day);
        if (digits) begin
            if (old_char(r.old_digits, 10) != bd / 10 || old_char(r.old_digits, 11) != bd % 10)
                ok = 1'b0;
            if (old_char(r.old_digits, 8) != bm / 10 || old_char(r.old_digits, 9) != bm % 10)
                ok = 1'b0;
            if (old_char(r.old_digits, 6) != (by / 10) % 10 || old_char(r.old_digits, 7) != by % 10)
                ok = 1'b0;
        end
        for (i = 0; i < 6; i++) wide[i] = old_char(r.old_digits, i);
        // century: 19 for the 1900s, 20 from 2000 on, else the old year digits again
        if (by >= 1900 && by < 2000) begin
            wide[6] = 4'd1;
            wide[7] = 4'd9;
        end else if (by >= 2000) begin
            wide[6] = 4'd2;
            wide[7] = 4'd0;
        end else begin
            wide[6] = old_char(r.old_digits, 6);
            wide[7] = old_char(r.old_digits, 7);
        end
        for (i = 8; i < 17; i++) wide[i] = old_char(r.old_digits, i - 2);
        sum = 0;
        for (i = 0; i < 17; i++) sum += wide[i] * CHECK_WEIGHT[i];
        wide[17] = digits ? CHECK_CODE[sum % 11] : 4'd0;
        for (i = 0; i < 18; i++) begin
            if (new_char(r, i) != wide[i]) ok = 1'b0;
        end
        if (r.valid_years != LONG_TERM_YEARS) begin
            ey = r.issue_year + r.valid_years;
            if (ey < ref_year_q)
                ok = 1'b0;
            else if (ey == ref_year_q && r.issue_month < ref_month_q)
                ok = 1'b0;
            else if (ey == ref_year_q && r.issue_month == ref_month_q && r.issue_day < ref_day_q)
                ok = 1'b0;
        end
        res.id_valid = ok;
        res.check_char = wide[17];
        return res;
    endfunction

    function automatic id_rec_t with_new_number(id_rec_t r);
        id_res_t    res;
        logic [7:0] cent;
        res = predict_id(r);
        if (r.birth_year >= 1900 && r.birth_year < 2000)
            cent = 8'h19;
        else if (r.birth_year >= 2000)
            cent = 8'h20;
        else
            cent = r.old_digits[35:28];
        r.new_head = {r.old_digits[59:36], cent, r.old_digits[35:32]};
        r.new_tail = {r.old_digits[31:0], res.check_char};
        return r;
    endfunction

    // consistent record; bm == 0 picks a random birth date in year by
    function automatic id_rec_t well_formed(int unsigned by, int unsigned bm, int unsigned bd);
        id_rec_t     r;
        int unsigned vy, base, iy, im, i;
        r = '0;
        if (bm == 0) begin
            bm = $urandom_range(1, 12);
            bd = $urandom_range(1, month_days(by, bm));
        end
        for (i = 0; i < 6; i++) r = set_old_char(r, i, $urandom_range(0, 9));
        r = set_old_char(r, 6, (by / 10) % 10);
        r = set_old_char(r, 7, by % 10);
        r = set_old_char(r, 8, bm / 10);
        r = set_old_char(r, 9, bm % 10);
        r = set_old_char(r, 10, bd / 10);
        r = set_old_char(r, 11, bd % 10);
        for (i = 12; i < 15; i++) r = set_old_char(r, i, $urandom_range(0, 9));
        r.birth_year = by;
        r.birth_month = bm;
        r.birth_day = bd;
        case ($urandom_range(0, 9))
            0, 1: vy = 5;
            2, 3: vy = 10;
            4, 5: vy = 20;
            6: vy = LONG_TERM_YEARS;
            7: vy = $urandom_range(0, 127);
            8: vy = $urandom_range(101, 127);
            default: vy = 0;
        endcase
        // issue date near the expiry boundary
        base = (vy >= ref_year_q) ? 0 : ref_year_q - vy;
        iy = base + $urandom_range(0, 3);
        if (iy > 0 && $urandom_range(0, 3) == 0) iy--;
        if (iy > 9999) iy = 9999;
        im = $urandom_range(1, 12);
        r.valid_years = vy;
        r.issue_year = iy;
        r.issue_month = im;
        r.issue_day = $urandom_range(1, month_days(iy, im));
        return with_new_number(r);
    endfunction

    task automatic send(id_rec_t r);
        pending_records.push_back(r);
        n_issued++;
    endtask

    task automatic queue_random(int count);
        id_rec_t     r;
        logic [191:0] noise;
        int unsigned by, pos, n;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: by = $urandom_range(0, 1899);
                1, 2, 3, 4: by = $urandom_range(1900, 1999);
                5, 6, 7: by = $urandom_range(2000, 2099);
                8: by = $urandom_range(2100, 9999);
                default: begin
                    case ($urandom_range(0, 5))
                        0: by = 0;
                        1: by = 1899;
                        2: by = 1900;
                        3: by = 1999;
                        4: by = 2000;
                        default: by = 9999;
                    endcase
                end
            endcase
            r = well_formed(by, 0, 0);
            case ($urandom_range(0, 19))
                11: begin
                    pos = $urandom_range(0, 17);
                    r = set_new_char(r, pos, new_char(r, pos) + $urandom_range(1, 15));
                end
                12: r = set_old_char(r, $urandom_range(0, 14), $urandom_range(10, 15));
                13: r.extra_chars = $urandom_range(1, 3);
                14: begin
                    if ($urandom_range(0, 1))
                        r.birth_month = $urandom_range(13, 16);
                    else if ($urandom_range(0, 1))
                        r.birth_day = 0;
                    else
                        r.birth_day = $urandom_range(month_days(by, r.birth_month) + 1, 63);
                end
                15: begin
                    if ($urandom_range(0, 1))
                        r.issue_month = $urandom_range(13, 16);
                    else if ($urandom_range(0, 1))
                        r.issue_day = 0;
                    else
                        r.issue_day = $urandom_range(
                            month_days(r.issue_year, r.issue_month) + 1, 63);
                end
                16: begin
                    r.valid_years = $urandom_range(0, 20);
                    if (ref_year_q > r.valid_years && ref_year_q - r.valid_years <= 10000) begin
                        r.issue_year = ref_year_q - r.valid_years - 1;
                        if (r.issue_day > month_days(r.issue_year, r.issue_month))
                            r.issue_day = month_days(r.issue_year, r.issue_month);
                    end
                end
                17: begin
                    pos = $urandom_range(6, 11);
                    r = set_old_char(r, pos,
                                     (old_char(r.old_digits, pos) + $urandom_range(1, 9)) % 10);
                    r = with_new_number(r);
                end
                18, 19: begin
                    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                    r = noise[$bits(id_rec_t)-1:0];
                end
                default: ;
            endcase
            send(r);
        end
    endtask

    task automatic wait_idle();
        while (n_sent != n_issued || predicted_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reference(logic [13:0] y, logic [13:0] m, logic [13:0] d);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [13:0]          val [3];
        int                   k;
        idx = '{CFG_REF_YEAR, CFG_REF_MONTH, CFG_REF_DAY};
        val = '{y, m, d};
        for (k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[k])
                CFG_REF_YEAR: ref_year_q = val[k];
                CFG_REF_MONTH: ref_month_q = val[k][3:0];
                CFG_REF_DAY: ref_day_q = val[k][4:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic log_mismatch(string what, int unsigned want, int unsigned got);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch on result %0d: %s expected %0d got %0d", n_results, what, want, got);
    endtask

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predicted_results.push_back(predict_id(drv_rec));
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_records.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    drv_rec <= pending_records.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        id_res_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < hold_pct);
            if (o_valid && !i_stall) begin
                n_results++;
                if (o_id_valid) n_ids_ok++;
                if (o_check_char == CHAR_X) n_x_checks++;
                if (predicted_results.size() == 0) begin
                    log_mismatch("transaction with none pending, id_valid", 0, o_id_valid);
                end else begin
                    want = predicted_results.pop_front();
                    if (o_id_valid !== want.id_valid)
                        log_mismatch("id_valid", want.id_valid, o_id_valid);
                    if (o_check_char !== want.check_char)
                        log_mismatch("check_char", want.check_char, o_check_char);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        id_rec_t    r;
        id_res_t    res;
        logic [3:0] targets [3];
        int         k;
        targets = '{CHAR_X, 4'd1, 4'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed records against the reset reference date
        send(well_formed(1985, 0, 0));
        send(well_formed(2000, 2, 29));
        send(well_formed(0, 2, 29));
        send(well_formed(1899, 0, 0));
        send(well_formed(1900, 2, 28));
        send(well_formed(2150, 0, 0));
        send(well_formed(9999, 12, 31));
        for (k = 0; k < 3; k++) begin
            do begin
                r = well_formed($urandom_range(1900, 2099), 0, 0);
                res = predict_id(r);
            end while (res.check_char != targets[k]);
            send(r);
        end
        send(set_old_char(well_formed(1970, 0, 0), 0, 4'd10));
        send(set_old_char(well_formed(1970, 0, 0), 14, 4'd15));
        send(set_new_char(well_formed(1990, 0, 0), 17, 4'd15));
        send(set_new_char(well_formed(1990, 0, 0), 17, 4'd11));
        r = well_formed(1995, 0, 0);
        r.extra_chars = 2'b01;
        send(r);
        r.extra_chars = 2'b10;
        send(r);
        // 1900 is not a leap year
        r = well_formed(1900, 2, 28);
        r.birth_day = 29;
        r = with_new_number(set_old_char(set_old_char(r, 10, 4'd2), 11, 4'd9));
        send(r);
        r = well_formed(1990, 4, 30);
        r.birth_day = 31;
        r = with_new_number(set_old_char(set_old_char(r, 10, 4'd3), 11, 4'd1));
        send(r);
        r = well_formed(1990, 0, 0);
        r.issue_month = 4'd15;
        r.issue_day = 6'd0;
        send(r);
        r = well_formed(1960, 0, 0);
        r.valid_years = LONG_TERM_YEARS;
        r.issue_year = 1950;
        send(r);
        r.valid_years = 7'd127;
        r.issue_year = 1900;
        send(r);
        // expiry on the reference date, then one day short
        r = well_formed(1980, 0, 0);
        r.valid_years = 7'd10;
        r.issue_year = 2007;
        r.issue_month = 4'd5;
        r.issue_day = 6'd10;
        send(r);
        r.issue_day = 6'd9;
        send(r);
        send('0);
        send('1);

        send_gap_pct = 0;
        hold_pct = 0;
        queue_random(140);
        wait_idle();

        write_reference(14'd0, 14'd1, 14'd1);
        send_gap_pct = 73;
        hold_pct = 0;
        queue_random(100);
        wait_idle();

        write_reference(14'd9999, 14'd12, 14'd31);
        send_gap_pct = 0;
        hold_pct = 73;
        queue_random(100);
        wait_idle();

        write_reference(14'd2030, 14'd7, 14'd15);
        send_gap_pct = 17;
        hold_pct = 17;
        queue_random(110);
        wait_idle();

        write_reference(14'h3FFF, 14'h3FFF, 14'h3FFF);
        send_gap_pct = 0;
        hold_pct = 0;
        queue_random(50);
        wait_idle();

        write_reference($urandom_range(2000, 2040), $urandom_range(1, 12), $urandom_range(1, 31));
        send_gap_pct = 17;
        hold_pct = 17;
        queue_random(50);
        wait_idle();

        $display("checked %0d records over 6 reference dates and 4 pacing modes", n_results);
        $display("%0d ids valid, %0d with check X, %0d mismatches", n_ids_ok, n_x_checks,
                 n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
